// ===== src/rlpe_pkg.sv =====
package rlpe_pkg;

    localparam int TICK_W  = 15;
    localparam int COUNT_W = 3;
    localparam int ORDER_W = 8;
    localparam int INDEX_W = 3;

    // register indexes
    localparam logic [INDEX_W-1:0] REG_COLOR_COUNT      = 3'd0;
    localparam logic [INDEX_W-1:0] REG_COLOR_ORDER      = 3'd1;
    localparam logic [INDEX_W-1:0] REG_ZERO_HIGH_TICKS  = 3'd2;
    localparam logic [INDEX_W-1:0] REG_ZERO_LOW_TICKS   = 3'd3;
    localparam logic [INDEX_W-1:0] REG_ONE_HIGH_TICKS   = 3'd4;
    localparam logic [INDEX_W-1:0] REG_ONE_LOW_TICKS    = 3'd5;
    localparam logic [INDEX_W-1:0] REG_RESET_HALF_TICKS = 3'd6;

    // reset values
    localparam logic [COUNT_W-1:0] RST_COLOR_COUNT      = 3'd3;
    localparam logic [ORDER_W-1:0] RST_COLOR_ORDER      = 8'd228;
    localparam logic [TICK_W-1:0]  RST_ZERO_HIGH_TICKS  = 15'd3;
    localparam logic [TICK_W-1:0]  RST_ZERO_LOW_TICKS   = 15'd9;
    localparam logic [TICK_W-1:0]  RST_ONE_HIGH_TICKS   = 15'd9;
    localparam logic [TICK_W-1:0]  RST_ONE_LOW_TICKS    = 15'd3;
    localparam logic [TICK_W-1:0]  RST_RESET_HALF_TICKS = 15'd250;

    // slot codes in color_order
    localparam logic [1:0] CODE_WHITE = 2'd0;
    localparam logic [1:0] CODE_RED   = 2'd1;
    localparam logic [1:0] CODE_GREEN = 2'd2;
    localparam logic [1:0] CODE_BLUE  = 2'd3;

    typedef struct packed {
        logic [COUNT_W-1:0] color_count;
        logic [ORDER_W-1:0] color_order;
        logic [TICK_W-1:0]  zero_high_ticks;
        logic [TICK_W-1:0]  zero_low_ticks;
        logic [TICK_W-1:0]  one_high_ticks;
        logic [TICK_W-1:0]  one_low_ticks;
        logic [TICK_W-1:0]  reset_half_ticks;
    } cfg_t;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       frame_end;
    } pix_t;

    typedef struct packed {
        logic              first_level;
        logic [TICK_W-1:0] first_ticks;
        logic              second_level;
        logic [TICK_W-1:0] second_ticks;
        logic              is_reset;
        logic              run_last;
    } sym_t;

endpackage

// ===== src/rlpe_cfg.sv =====
module rlpe_cfg (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [rlpe_pkg::INDEX_W-1:0]   cfg_index,
    input  logic [rlpe_pkg::TICK_W-1:0]    cfg_data,
    output rlpe_pkg::cfg_t                 cfg
);
    import rlpe_pkg::*;

    cfg_t cfg_reg;
    logic wr;

    assign cfg_ready = 1'b1;
    assign wr        = cfg_valid && cfg_ready;
    assign cfg       = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.color_count      <= RST_COLOR_COUNT;
            cfg_reg.color_order      <= RST_COLOR_ORDER;
            cfg_reg.zero_high_ticks  <= RST_ZERO_HIGH_TICKS;
            cfg_reg.zero_low_ticks   <= RST_ZERO_LOW_TICKS;
            cfg_reg.one_high_ticks   <= RST_ONE_HIGH_TICKS;
            cfg_reg.one_low_ticks    <= RST_ONE_LOW_TICKS;
            cfg_reg.reset_half_ticks <= RST_RESET_HALF_TICKS;
        end else if (wr) begin
            case (cfg_index)
                REG_COLOR_COUNT:      cfg_reg.color_count      <= cfg_data[COUNT_W-1:0];
                REG_COLOR_ORDER:      cfg_reg.color_order      <= cfg_data[ORDER_W-1:0];
                REG_ZERO_HIGH_TICKS:  cfg_reg.zero_high_ticks  <= cfg_data;
                REG_ZERO_LOW_TICKS:   cfg_reg.zero_low_ticks   <= cfg_data;
                REG_ONE_HIGH_TICKS:   cfg_reg.one_high_ticks   <= cfg_data;
                REG_ONE_LOW_TICKS:    cfg_reg.one_low_ticks    <= cfg_data;
                REG_RESET_HALF_TICKS: cfg_reg.reset_half_ticks <= cfg_data;
                default: ;
            endcase
        end
    end

endmodule

// ===== src/rlpe_serializer.sv =====
module rlpe_serializer #(
    parameter int MAX_SLOTS = 4
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  rlpe_pkg::cfg_t cfg,
    input  logic           pix_valid,
    output logic           pix_take,
    input  rlpe_pkg::pix_t pix,
    output logic           sym_valid,
    input  logic           sym_ready,
    output rlpe_pkg::sym_t sym
);
    import rlpe_pkg::*;

    localparam int SLOT_W = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;

    logic              busy_reg;
    logic              rst_phase_reg;
    pix_t              pix_reg;
    logic [SLOT_W-1:0] slot_reg;
    logic [2:0]        bit_reg;

    logic [COUNT_W-1:0] slots_eff;
    logic [1:0]         code;
    logic [7:0]         byte_sel;
    logic               data_bit;
    logic               last_slot;
    logic               last_data;
    logic               step;
    logic               item_done;

    always_comb begin
        if (cfg.color_count == '0) begin
            slots_eff = COUNT_W'(1);
        end else if (cfg.color_count > COUNT_W'(MAX_SLOTS)) begin
            slots_eff = COUNT_W'(MAX_SLOTS);
        end else begin
            slots_eff = cfg.color_count;
        end
    end

    assign code = cfg.color_order[{slot_reg, 1'b0} +: 2];

    always_comb begin
        case (code)
            CODE_WHITE: byte_sel = 8'd0;
            CODE_RED:   byte_sel = pix_reg.red;
            CODE_GREEN: byte_sel = pix_reg.green;
            CODE_BLUE:  byte_sel = pix_reg.blue;
            default:    byte_sel = 8'd0;
        endcase
    end

    // msb first: bit_reg counts 0..7, so bit ~bit_reg
    assign data_bit  = byte_sel[~bit_reg];
    assign last_slot = (COUNT_W'(slot_reg) == slots_eff - COUNT_W'(1));
    assign last_data = !rst_phase_reg && last_slot && (bit_reg == 3'd7);
    assign step      = busy_reg && sym_ready;
    assign item_done = step && (rst_phase_reg || (last_data && !pix_reg.frame_end));
    assign pix_take  = pix_valid && (!busy_reg || item_done);
    assign sym_valid = busy_reg;

    always_comb begin
        if (rst_phase_reg) begin
            sym.first_level  = 1'b0;
            sym.first_ticks  = cfg.reset_half_ticks;
            sym.second_level = 1'b0;
            sym.second_ticks = cfg.reset_half_ticks;
            sym.is_reset     = 1'b1;
            sym.run_last     = 1'b1;
        end else begin
            sym.first_level  = 1'b1;
            sym.first_ticks  = data_bit ? cfg.one_high_ticks : cfg.zero_high_ticks;
            sym.second_level = 1'b0;
            sym.second_ticks = data_bit ? cfg.one_low_ticks : cfg.zero_low_ticks;
            sym.is_reset     = 1'b0;
            sym.run_last     = last_data && !pix_reg.frame_end;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg      <= 1'b0;
            rst_phase_reg <= 1'b0;
            slot_reg      <= '0;
            bit_reg       <= '0;
        end else if (pix_take) begin
            busy_reg      <= 1'b1;
            rst_phase_reg <= 1'b0;
            slot_reg      <= '0;
            bit_reg       <= '0;
        end else if (item_done) begin
            busy_reg      <= 1'b0;
            rst_phase_reg <= 1'b0;
        end else if (step) begin
            if (last_data) begin
                rst_phase_reg <= 1'b1;
            end else if (bit_reg == 3'd7) begin
                bit_reg  <= '0;
                slot_reg <= slot_reg + SLOT_W'(1);
            end else begin
                bit_reg <= bit_reg + 3'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (pix_take) begin
            pix_reg <= pix;
        end
    end

    a_rst_phase_only_on_frame_end: assert property (@(posedge aclk) disable iff (!aresetn)
        rst_phase_reg |-> busy_reg && pix_reg.frame_end && last_slot && (bit_reg == 3'd7))
        else $error("reset symbol phase without a finished frame-end pixel");

    a_load_starts_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        pix_take |=> busy_reg && (slot_reg == '0) && (bit_reg == 3'd0) && !rst_phase_reg)
        else $error("pixel load did not restart the bit sequencer");

    a_slot_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> (COUNT_W'(slot_reg) < slots_eff))
        else $error("slot index beyond configured slot count");

    a_done_after_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (step && sym.run_last && !pix_valid) |=> !busy_reg)
        else $error("sequencer still busy after last symbol of a pixel");

endmodule

// ===== src/rlpe_out_reg.sv =====
module rlpe_out_reg (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           in_valid,
    output logic           in_ready,
    input  rlpe_pkg::sym_t in_sym,
    output logic           m_valid,
    input  logic           m_ready,
    output rlpe_pkg::sym_t m_sym
);
    import rlpe_pkg::*;

    logic valid_reg;
    sym_t sym_reg;

    assign in_ready = !valid_reg || m_ready;
    assign m_valid  = valid_reg;
    assign m_sym    = sym_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            sym_reg <= in_sym;
        end
    end

endmodule

// ===== src/rgb_led_pulse_encoder.sv =====
// Channel  | Direction | Handshake            | Payload
// s_       | in        | s_valid / s_ready    | s_red, s_green, s_blue, s_frame_end
// m_       | out       | m_valid / m_ready    | m_first_level .. m_run_last
// cfg_     | in        | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// One symbol per cycle on m_ while pixels wait and m_ready is high: a pixel gives 8 * slots symbols,
// plus the reset symbol on a frame-end pixel (8 to 33). The bit sequencer sets this rate.
// A one-pixel input buffer takes the next pixel while the current one is sent.
// Reset (aresetn low, synchronous) empties the buffer and the output register
// and loads the default timing. m_ready low holds the sequencer in place.
module rgb_led_pulse_encoder #(
    parameter int MAX_SLOTS = 4
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [7:0]                    s_red,
    input  logic [7:0]                    s_green,
    input  logic [7:0]                    s_blue,
    input  logic                          s_frame_end,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic                          m_first_level,
    output logic [rlpe_pkg::TICK_W-1:0]   m_first_ticks,
    output logic                          m_second_level,
    output logic [rlpe_pkg::TICK_W-1:0]   m_second_ticks,
    output logic                          m_is_reset,
    output logic                          m_run_last,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [rlpe_pkg::INDEX_W-1:0]  cfg_index,
    input  logic [rlpe_pkg::TICK_W-1:0]   cfg_data
);
    import rlpe_pkg::*;

    cfg_t cfg;
    logic pend_valid_reg;
    pix_t pend_reg;
    logic pix_take;
    logic sym_valid;
    logic sym_ready;
    sym_t sym;
    sym_t m_sym;

    assign s_ready = !pend_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_valid_reg <= 1'b0;
        end else if (s_valid && s_ready) begin
            pend_valid_reg <= 1'b1;
        end else if (pix_take) begin
            pend_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            pend_reg.red       <= s_red;
            pend_reg.green     <= s_green;
            pend_reg.blue      <= s_blue;
            pend_reg.frame_end <= s_frame_end;
        end
    end

    rlpe_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    rlpe_serializer #(
        .MAX_SLOTS (MAX_SLOTS)
    ) u_ser (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg),
        .pix_valid (pend_valid_reg),
        .pix_take  (pix_take),
        .pix       (pend_reg),
        .sym_valid (sym_valid),
        .sym_ready (sym_ready),
        .sym       (sym)
    );

    rlpe_out_reg u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (sym_valid),
        .in_ready (sym_ready),
        .in_sym   (sym),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_sym    (m_sym)
    );

    assign m_first_level  = m_sym.first_level;
    assign m_first_ticks  = m_sym.first_ticks;
    assign m_second_level = m_sym.second_level;
    assign m_second_ticks = m_sym.second_ticks;
    assign m_is_reset     = m_sym.is_reset;
    assign m_run_last     = m_sym.run_last;

endmodule
